@@ hw/rtl/sfa_pkg.sv @@
`default_nettype none
package sfa_pkg;

   localparam int OPCODE_W    = 2;
   localparam int SECTOR_W    = 6;
   localparam int OFFSET_W    = 13;
   localparam int DATA_W      = 8;
   localparam int COUNT_W     = 7;

   localparam logic [OPCODE_W-1:0] OP_READ    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ERASE   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_PROGRAM = 2'd2;

   localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      logic              load;
      logic [DATA_W-1:0] read_data;
      logic              status;
      logic              last;
   } sfa_out_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } sfa_mem_ctl_type;

endpackage
`default_nettype wire

@@ hw/rtl/sfa_req_if.sv @@
`default_nettype none
interface sfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfa_pkg::OPCODE_W-1:0]  opcode;
   logic [sfa_pkg::SECTOR_W-1:0]  sector;
   logic [sfa_pkg::OFFSET_W-1:0]  offset;
   logic [sfa_pkg::DATA_W-1:0]    data;
   logic [sfa_pkg::COUNT_W-1:0]   read_count;

   modport source (output valid, output opcode, output sector, output offset,
                   output data, output read_count, input ready);
   modport sink   (input valid, input opcode, input sector, input offset,
                   input data, input read_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sfa_rsp_if.sv @@
`default_nettype none
interface sfa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sfa_pkg::DATA_W-1:0]  read_data;
   logic                        status;
   logic                        last;

   modport source (output valid, output read_data, output status, output last,
                   input ready);
   modport sink   (input valid, input read_data, input status, input last,
                   output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sector_flash_array_model.sv @@
// channel   dir   handshake      payload
// req_if    in    valid/ready    opcode, sector, offset, data, read_count
// rsp_if    out   valid/ready    read_data, status, last
//
// after reset a clearing pass writes 0xFF to every byte
// one request at a time; address setup registers sector * SECTOR_BYTES, then adds the offset
// read: S_RD then S_RDW for each byte on the single memory port; program: read then write
// erase: one byte written per cycle
// rsp_if has an output register, so a stalled response holds only the sequencer
`default_nettype none
module sector_flash_array_model #(
   parameter int SECTOR_BYTES = 4096,
   parameter int SECTOR_COUNT = 32,
   parameter int MAX_BURST    = 64
) (
   input  wire        clock,
   input  wire        reset,
   sfa_req_if.sink    req_if,
   sfa_rsp_if.source  rsp_if
);

   localparam int STORE_BYTES = SECTOR_BYTES * SECTOR_COUNT;
   localparam int AW = $clog2(STORE_BYTES);

   sfa_pkg::sfa_out_type       out;
   sfa_pkg::sfa_mem_ctl_type   mem_ctl;
   logic [AW-1:0]              mem_addr;
   logic [sfa_pkg::DATA_W-1:0] mem_wdata;
   logic [sfa_pkg::DATA_W-1:0] mem_rdata;
   logic                       rsp_free;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sfa_pkg::DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   logic                       rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff,  rsp_last_in;

   sfa_seq #(
      .SECTOR_BYTES (SECTOR_BYTES),
      .SECTOR_COUNT (SECTOR_COUNT),
      .MAX_BURST    (MAX_BURST),
      .AW           (AW)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .req_opcode     (req_if.opcode),
      .req_sector     (req_if.sector),
      .req_offset     (req_if.offset),
      .req_data       (req_if.data),
      .req_read_count (req_if.read_count),
      .rsp_free       (rsp_free),
      .out            (out),
      .mem_ctl        (mem_ctl),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .mem_rdata      (mem_rdata)
   );

   sfa_mem #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock (clock),
      .ctl   (mem_ctl),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (out.load) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = out.read_data;
         rsp_status_in = out.status;
         rsp_last_in   = out.last;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.read_data = rsp_data_ff;
   assign rsp_if.status    = rsp_status_ff;
   assign rsp_if.last      = rsp_last_ff;

endmodule
`default_nettype wire

@@ hw/rtl/sfa_mem.sv @@
`default_nettype none
module sfa_mem #(
   parameter int DEPTH = 131072,
   parameter int AW    = 17
) (
   input  wire                           clock,
   input  sfa_pkg::sfa_mem_ctl_type      ctl,
   input  wire  [AW-1:0]                 addr,
   input  wire  [sfa_pkg::DATA_W-1:0]    wdata,
   output logic [sfa_pkg::DATA_W-1:0]    rdata
);

   logic [sfa_pkg::DATA_W-1:0] mem [DEPTH];
   logic [sfa_pkg::DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ hw/rtl/sfa_seq.sv @@
`default_nettype none
module sfa_seq #(
   parameter int SECTOR_BYTES = 4096,
   parameter int SECTOR_COUNT = 32,
   parameter int MAX_BURST    = 64,
   parameter int AW           = 17
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  [sfa_pkg::OPCODE_W-1:0]  req_opcode,
   input  wire  [sfa_pkg::SECTOR_W-1:0]  req_sector,
   input  wire  [sfa_pkg::OFFSET_W-1:0]  req_offset,
   input  wire  [sfa_pkg::DATA_W-1:0]    req_data,
   input  wire  [sfa_pkg::COUNT_W-1:0]   req_read_count,
   input  wire                           rsp_free,
   output sfa_pkg::sfa_out_type          out,
   output sfa_pkg::sfa_mem_ctl_type      mem_ctl,
   output logic [AW-1:0]                 mem_addr,
   output logic [sfa_pkg::DATA_W-1:0]    mem_wdata,
   input  wire  [sfa_pkg::DATA_W-1:0]    mem_rdata
);

   localparam int STORE_BYTES = SECTOR_BYTES * SECTOR_COUNT;
   localparam int PW  = $clog2(64 * SECTOR_BYTES);
   localparam int LW0 = $clog2(64 * SECTOR_BYTES + 8256);
   localparam int LW  = (AW + 1 > LW0) ? AW + 1 : LW0;

   localparam logic [PW-1:0]  SB_P      = PW'(SECTOR_BYTES);
   localparam logic [8:0]     SC_LIM    = 9'(SECTOR_COUNT);
   localparam logic [16:0]    SB_LIM    = 17'(SECTOR_BYTES);
   localparam logic [sfa_pkg::COUNT_W-1:0] MB_LIM = sfa_pkg::COUNT_W'(MAX_BURST);
   localparam logic [LW-1:0]  STORE_LIM = LW'(STORE_BYTES);
   localparam logic [AW-1:0]  STORE_END = AW'(STORE_BYTES - 1);
   localparam logic [AW-1:0]  SB_SPAN   = AW'(SECTOR_BYTES - 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ADDR  = 4'd2;
   localparam logic [3:0] S_ERASE = 4'd3;
   localparam logic [3:0] S_PRD   = 4'd4;
   localparam logic [3:0] S_PWR   = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_RDW   = 4'd7;
   localparam logic [3:0] S_EMIT  = 4'd8;

   logic [3:0]                    state_ff,  state_in;
   logic [sfa_pkg::OPCODE_W-1:0]  opcode_ff, opcode_in;
   logic [sfa_pkg::SECTOR_W-1:0]  sector_ff, sector_in;
   logic [sfa_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic [sfa_pkg::DATA_W-1:0]    data_ff,   data_in;
   logic [sfa_pkg::COUNT_W-1:0]   count_ff,  count_in;
   logic [PW-1:0]                 prod_ff,   prod_in;
   logic [LW-1:0]                 lin_ff,    lin_in;
   logic [AW-1:0]                 walk_ff,   walk_in;
   logic [AW-1:0]                 end_ff,    end_in;
   logic                          status_ff, status_in;
   logic                          bad_sector;
   logic                          bad_offset;
   logic                          in_range;

   assign bad_sector = {3'b000, sector_ff} >= SC_LIM;
   assign bad_offset = {4'b0000, offset_ff} >= SB_LIM;
   assign in_range   = lin_ff < STORE_LIM;

   always_comb begin
      state_in  = state_ff;
      opcode_in = opcode_ff;
      sector_in = sector_ff;
      offset_in = offset_ff;
      data_in   = data_ff;
      count_in  = count_ff;
      prod_in   = prod_ff;
      lin_in    = lin_ff;
      walk_in   = walk_ff;
      end_in    = end_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      out       = '0;
      mem_ctl   = '0;
      mem_addr  = walk_ff;
      mem_wdata = sfa_pkg::ERASED_BYTE;

      case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
            walk_in = walk_ff + AW'(1);
            if (walk_ff == end_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               opcode_in = req_opcode;
               sector_in = req_sector;
               offset_in = req_offset;
               data_in   = req_data;
               count_in  = req_read_count;
               prod_in   = PW'(req_sector) * SB_P;
               state_in  = S_ADDR;
            end
         end
         S_ADDR: begin
            lin_in    = LW'(prod_ff) + LW'(offset_ff);
            status_in = sfa_pkg::STATUS_ERR;
            state_in  = S_EMIT;
            case (opcode_ff)
               sfa_pkg::OP_READ: begin
                  if (count_ff != '0) begin
                     count_in = (count_ff > MB_LIM) ? MB_LIM : count_ff;
                     state_in = S_RD;
                  end
               end
               sfa_pkg::OP_ERASE: begin
                  if (!bad_sector) begin
                     walk_in  = prod_ff[AW-1:0];
                     end_in   = prod_ff[AW-1:0] + SB_SPAN;
                     state_in = S_ERASE;
                  end
               end
               sfa_pkg::OP_PROGRAM: begin
                  if (!bad_sector && !bad_offset) begin
                     state_in = S_PRD;
                  end
               end
               default: begin
                  state_in = S_EMIT;
               end
            endcase
         end
         S_ERASE: begin
            mem_ctl.wr_en = 1'b1;
            walk_in = walk_ff + AW'(1);
            if (walk_ff == end_ff) begin
               status_in = sfa_pkg::STATUS_OK;
               state_in  = S_EMIT;
            end
         end
         S_PRD: begin
            mem_ctl.rd_en = 1'b1;
            mem_addr = lin_ff[AW-1:0];
            state_in = S_PWR;
         end
         S_PWR: begin
            mem_ctl.wr_en = 1'b1;
            mem_addr  = lin_ff[AW-1:0];
            mem_wdata = mem_rdata & data_ff;
            status_in = sfa_pkg::STATUS_OK;
            state_in  = S_EMIT;
         end
         S_RD: begin
            mem_ctl.rd_en = in_range;
            mem_addr  = lin_ff[AW-1:0];
            status_in = in_range ? sfa_pkg::STATUS_OK : sfa_pkg::STATUS_ERR;
            state_in  = S_RDW;
         end
         S_RDW: begin
            if (rsp_free) begin
               out.load      = 1'b1;
               out.read_data = status_ff ? sfa_pkg::ERASED_BYTE : mem_rdata;
               out.status    = status_ff;
               out.last      = (count_ff == sfa_pkg::COUNT_W'(1));
               if (count_ff == sfa_pkg::COUNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  count_in = count_ff - sfa_pkg::COUNT_W'(1);
                  lin_in   = lin_ff + LW'(1);
                  state_in = S_RD;
               end
            end
         end
         S_EMIT: begin
            if (rsp_free) begin
               out.load      = 1'b1;
               out.read_data = sfa_pkg::ERASED_BYTE;
               out.status    = status_ff;
               out.last      = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         walk_ff  <= '0;
         end_ff   <= STORE_END;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
         end_ff   <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff <= opcode_in;
      sector_ff <= sector_in;
      offset_ff <= offset_in;
      data_ff   <= data_in;
      count_ff  <= count_in;
      prod_ff   <= prod_in;
      lin_ff    <= lin_in;
      status_ff <= status_in;
   end

endmodule
`default_nettype wire

@@ hw/rtl/sfa_checker.sv @@
`default_nettype none
module sfa_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_ready,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire [sfa_pkg::DATA_W-1:0]   rsp_read_data,
   input wire                         rsp_status,
   input wire                         rsp_last
);

   // clearing pass and empty output after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

   // one request at a time
   a_busy_after_accept: assert property (@(posedge clock)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // errors always carry the erased byte
   a_error_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_read_data == sfa_pkg::ERASED_BYTE)
      else $error("error response with data");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_status) && $stable(rsp_last))
      else $error("stalled response changed");

endmodule

bind sector_flash_array_model sfa_checker u_sfa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_read_data (rsp_if.read_data),
   .rsp_status    (rsp_if.status),
   .rsp_last      (rsp_if.last)
);
`default_nettype wire
